// File: hw/rtl/assert_macros.svh
// Assertion macros for the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("assertion failed");

// Clocked assertion that is also checked while reset is asserted.
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

// File: hw/rtl/ltcf_pkg.sv
// Package with the shared types, codes and constants of the capacity forecast block.
package ltcf_pkg;

  // Widths of the internal arithmetic.
  localparam int WideW    = 128;
  localparam int SumW     = 64;
  localparam int OutW     = 48;
  localparam int DaysW    = 17;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;
  localparam int FracBits = 16;
  localparam int MulSteps = 64;
  localparam int DivSteps = 128;
  localparam int StepCntW = 7;
  localparam int DaysMax  = 65535;

  // Warning test: projected_long * WarnMul > capacity * WarnCap in Q.16.
  localparam int WarnMul  = 5;
  localparam int WarnCap  = 4;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_CAPACITY,
    REG_MIN_SAMPLES,
    REG_SHORT_HORIZON,
    REG_LONG_HORIZON,
    REG_CRITICAL_DAYS
  } cfg_reg_e;

  // Result grades.
  typedef enum logic [1:0] {
    GRADE_HEALTHY,
    GRADE_WARNING,
    GRADE_CRITICAL
  } grade_e;

  // Datapath operations, issued in this order for each forecast.
  typedef enum logic [3:0] {
    OP_N_SXY,
    OP_SX_SY,
    OP_N_SXX,
    OP_SX_SX,
    OP_SLOPE,
    OP_ICPT_MUL,
    OP_ICPT_DIV,
    OP_PROJ_S,
    OP_PROJ_L,
    OP_DAYS
  } dp_op_e;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_ISSUE,
    ST_WAIT,
    ST_EMIT
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic   accept;
    logic   clear;
    logic   start;
    logic   emit;
    dp_op_e op;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic count_ok;
    logic op_done;
  } dp_status_t;

  // Operation that follows a given one.
  function automatic dp_op_e next_op(input dp_op_e op);
    dp_op_e r;
    case (op)
      OP_N_SXY:    r = OP_SX_SY;
      OP_SX_SY:    r = OP_N_SXX;
      OP_N_SXX:    r = OP_SX_SX;
      OP_SX_SX:    r = OP_SLOPE;
      OP_SLOPE:    r = OP_ICPT_MUL;
      OP_ICPT_MUL: r = OP_ICPT_DIV;
      OP_ICPT_DIV: r = OP_PROJ_S;
      OP_PROJ_S:   r = OP_PROJ_L;
      OP_PROJ_L:   r = OP_DAYS;
      default:     r = OP_DAYS;
    endcase
    return r;
  endfunction

endpackage

// File: hw/rtl/ltcf_arith.sv
// Shared bit-serial unit: shift-add multiplier and restoring divider.
module ltcf_arith (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic                       div_i,
  input  logic [ltcf_pkg::WideW-1:0] a_i,
  input  logic [ltcf_pkg::WideW-1:0] b_i,
  output logic                       done_o,
  output logic [ltcf_pkg::WideW-1:0] result_o
);
  import ltcf_pkg::*;

  logic                run_q, div_q, done_q;
  logic [StepCntW-1:0] cnt_q;
  logic [WideW-1:0]    x_q, y_q, r_q;
  logic [WideW-1:0]    rem_shift, rem_trial, mul_sum;
  logic                fits;

  // One divider step: shift in the next dividend bit and try a subtract.
  assign rem_shift = {r_q[WideW-2:0], x_q[WideW-1]};
  assign fits      = (rem_shift >= y_q);
  assign rem_trial = rem_shift - y_q;

  // One multiplier step: add the shifted multiplicand when the bit is set.
  assign mul_sum = r_q + (y_q[0] ? x_q : '0);

  // Step control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      div_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        div_q <= div_i;
        cnt_q <= div_i ? StepCntW'(DivSteps - 1) : StepCntW'(MulSteps - 1);
      end else if (run_q) begin
        if (cnt_q == '0) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  // Operand and partial result registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q <= a_i;
      y_q <= b_i;
      r_q <= '0;
    end else if (run_q) begin
      if (div_q) begin
        r_q <= fits ? rem_trial : rem_shift;
        x_q <= {x_q[WideW-2:0], fits};
      end else begin
        r_q <= mul_sum;
        x_q <= {x_q[WideW-2:0], 1'b0};
        y_q <= {1'b0, y_q[WideW-1:1]};
      end
    end
  end

  assign done_o   = done_q;
  assign result_o = div_q ? x_q : r_q;

endmodule

// File: hw/rtl/ltcf_dp.sv
// Datapath: running sums, configuration registers, fit arithmetic and result registers.
module ltcf_dp #(
  parameter int MAX_SAMPLES = 65536,
  parameter int SAMPLE_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ltcf_pkg::dp_cmd_t             cmd_i,
  output ltcf_pkg::dp_status_t          status_o,
  input  logic [31:0]                   usage_sample_i,
  input  logic                          cfg_we_i,
  input  logic [ltcf_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ltcf_pkg::CfgDataW-1:0] cfg_wdata_i,
  output logic                          done_o,
  output logic [31:0]                   current_usage_o,
  output logic signed [47:0]            projected_short_o,
  output logic signed [47:0]            projected_long_o,
  output logic signed [47:0]            growth_slope_o,
  output logic signed [16:0]            days_left_o,
  output logic [1:0]                    grade_o
);
  import ltcf_pkg::*;

  localparam int IdxW = $clog2(MAX_SAMPLES);
  localparam int CntW = $clog2(MAX_SAMPLES + 1);
  localparam int WarnW = OutW + 4;
  localparam int ProdW = IdxW + SAMPLE_BITS;
  localparam int SqW   = 2 * IdxW;

  // Saturate a wide two's complement value to the output width.
  function automatic logic [OutW-1:0] sat48(input logic [WideW-1:0] v);
    logic [WideW-OutW:0] top;
    top = v[WideW-1:OutW-1];
    if (top == '0 || top == '1) begin
      return v[OutW-1:0];
    end else if (v[WideW-1]) begin
      return {1'b1, {(OutW-1){1'b0}}};
    end else begin
      return {1'b0, {(OutW-1){1'b1}}};
    end
  endfunction

  // Sums and counters.
  logic [CntW-1:0]        cnt_q;
  logic [SumW-1:0]        sx_q, sxx_q, sy_q, sxy_q;
  logic [SAMPLE_BITS-1:0] cur_q;

  // Configuration.
  logic [31:0] cap_q;
  logic [15:0] min_q, crit_q;
  logic [9:0]  sh_q, lh_q;

  // Intermediate results.
  logic [WideW-1:0]       t1_q, num_q, den_q, icpt_q;
  logic [OutW-1:0]        slope_q, projs_q, projl_q;
  logic [DaysW-1:0]       days_q;
  dp_op_e                 op_q;
  logic                   done_q;

  // Result registers.
  logic [31:0]      out_cur_q;
  logic [OutW-1:0]  out_ps_q, out_pl_q, out_slope_q;
  logic [DaysW-1:0] out_days_q;
  logic [1:0]       out_grade_q;

  // Arithmetic unit connections.
  logic             arith_div, arith_done;
  logic [WideW-1:0] arith_a, arith_b, res;

  // Per-sample products.
  logic [SAMPLE_BITS-1:0] x_in;
  logic [IdxW-1:0]        idx;
  logic [SumW-1:0]        ix_prod, ii_prod;

  assign x_in    = usage_sample_i[SAMPLE_BITS-1:0];
  assign idx     = cnt_q[IdxW-1:0];
  assign ix_prod = SumW'(ProdW'(idx) * ProdW'(x_in));
  assign ii_prod = SumW'(SqW'(idx) * SqW'(idx));

  // Derived operands.
  logic [SumW-1:0]  n64, slope_ext, slope_mag;
  logic [WideW-1:0] num_sh, sy_sh, cap_gap;
  logic             num_sh_neg, slope_pos, below_cap;

  assign n64        = SumW'(cnt_q);
  assign slope_ext  = {{(SumW-OutW){slope_q[OutW-1]}}, slope_q};
  assign slope_mag  = slope_q[OutW-1] ? (SumW'(0) - slope_ext) : slope_ext;
  assign num_sh     = num_q << FracBits;
  assign num_sh_neg = num_sh[WideW-1];
  assign sy_sh      = WideW'(sy_q) << FracBits;
  assign cap_gap    = (WideW'(cap_q) - WideW'(cur_q)) << FracBits;
  assign slope_pos  = !slope_q[OutW-1] && (slope_q != '0);
  assign below_cap  = (32'(cur_q) < cap_q);

  // Operand selection for the shared unit.
  always_comb begin
    arith_a   = '0;
    arith_b   = '0;
    arith_div = 1'b0;
    case (cmd_i.op)
      OP_N_SXY: begin
        arith_a = WideW'(sxy_q);
        arith_b = WideW'(n64);
      end
      OP_SX_SY: begin
        arith_a = WideW'(sy_q);
        arith_b = WideW'(sx_q);
      end
      OP_N_SXX: begin
        arith_a = WideW'(sxx_q);
        arith_b = WideW'(n64);
      end
      OP_SX_SX: begin
        arith_a = WideW'(sx_q);
        arith_b = WideW'(sx_q);
      end
      OP_SLOPE: begin
        arith_a   = num_sh_neg ? (WideW'(0) - num_sh) : num_sh;
        arith_b   = den_q;
        arith_div = 1'b1;
      end
      OP_ICPT_MUL: begin
        arith_a = WideW'(slope_mag);
        arith_b = WideW'(sx_q);
      end
      OP_ICPT_DIV: begin
        arith_a   = t1_q[WideW-1] ? (WideW'(0) - t1_q) : t1_q;
        arith_b   = WideW'(n64);
        arith_div = 1'b1;
      end
      OP_PROJ_S: begin
        arith_a = WideW'(slope_mag);
        arith_b = WideW'(n64 + SumW'(sh_q));
      end
      OP_PROJ_L: begin
        arith_a = WideW'(slope_mag);
        arith_b = WideW'(n64 + SumW'(lh_q));
      end
      OP_DAYS: begin
        arith_a   = cap_gap;
        arith_b   = WideW'(slope_q);
        arith_div = 1'b1;
      end
      default: begin
        arith_a = '0;
      end
    endcase
  end

  ltcf_arith u_arith (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cmd_i.start),
    .div_i    (arith_div),
    .a_i      (arith_a),
    .b_i      (arith_b),
    .done_o   (arith_done),
    .result_o (res)
  );

  // Signed product for the projections.
  logic [WideW-1:0] res_signed;
  assign res_signed = slope_q[OutW-1] ? (WideW'(0) - res) : res;

  // Grade from days left and the long projection.
  logic [WarnW-1:0] pl_ext, pl_scaled, cap_scaled;
  logic             days_pos, is_crit, is_warn;
  logic [1:0]       grade_d;

  assign days_pos   = !days_q[DaysW-1] && (days_q != '0);
  assign is_crit    = days_pos && (days_q[15:0] < crit_q);
  assign pl_ext     = {{(WarnW-OutW){projl_q[OutW-1]}}, projl_q};
  assign pl_scaled  = WarnW'(pl_ext * WarnW'(WarnMul));
  assign cap_scaled = WarnW'(WarnW'(cap_q) * WarnW'(WarnCap)) << FracBits;
  assign is_warn    = $signed(pl_scaled) > $signed(cap_scaled);

  always_comb begin
    if (is_crit) begin
      grade_d = GRADE_CRITICAL;
    end else if (is_warn) begin
      grade_d = GRADE_WARNING;
    end else begin
      grade_d = GRADE_HEALTHY;
    end
  end

  // Sums, count and configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      sx_q   <= '0;
      sxx_q  <= '0;
      sy_q   <= '0;
      sxy_q  <= '0;
      cur_q  <= '0;
      cap_q  <= 32'd100;
      min_q  <= 16'd7;
      sh_q   <= 10'd7;
      lh_q   <= 10'd30;
      crit_q <= 16'd30;
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.emit;
      if (cmd_i.clear) begin
        cnt_q <= '0;
        sx_q  <= '0;
        sxx_q <= '0;
        sy_q  <= '0;
        sxy_q <= '0;
      end else if (cmd_i.accept) begin
        cur_q <= x_in;
        if (cnt_q < CntW'(MAX_SAMPLES)) begin
          cnt_q <= cnt_q + 1'b1;
          sx_q  <= sx_q + SumW'(idx);
          sxx_q <= sxx_q + ii_prod;
          sy_q  <= sy_q + SumW'(x_in);
          sxy_q <= sxy_q + ix_prod;
        end
      end
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_CAPACITY:      cap_q  <= cfg_wdata_i;
          REG_MIN_SAMPLES:   min_q  <= cfg_wdata_i[15:0];
          REG_SHORT_HORIZON: sh_q   <= cfg_wdata_i[9:0];
          REG_LONG_HORIZON:  lh_q   <= cfg_wdata_i[9:0];
          REG_CRITICAL_DAYS: crit_q <= cfg_wdata_i[15:0];
          default:           cap_q  <= cap_q;
        endcase
      end
    end
  end

  // Write back each operation's result when the shared unit finishes, and load the result registers on emit.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      op_q <= cmd_i.op;
    end
    if (arith_done) begin
      case (op_q)
        OP_N_SXY:    t1_q  <= res;
        OP_SX_SY:    num_q <= t1_q - res;
        OP_N_SXX:    t1_q  <= res;
        OP_SX_SX:    den_q <= t1_q - res;
        OP_SLOPE: begin
          if (den_q == '0 || den_q[WideW-1]) begin
            slope_q <= '0;
          end else begin
            slope_q <= sat48(num_sh_neg ? (WideW'(0) - res) : res);
          end
        end
        OP_ICPT_MUL: t1_q   <= slope_q[OutW-1] ? (sy_sh + res) : (sy_sh - res);
        OP_ICPT_DIV: icpt_q <= t1_q[WideW-1] ? (WideW'(0) - res) : res;
        OP_PROJ_S:   projs_q <= sat48(icpt_q + res_signed);
        OP_PROJ_L:   projl_q <= sat48(icpt_q + res_signed);
        OP_DAYS: begin
          if (slope_pos && below_cap) begin
            days_q <= (res > WideW'(DaysMax)) ? DaysW'(DaysMax) : res[DaysW-1:0];
          end else begin
            days_q <= '1;
          end
        end
        default: t1_q <= t1_q;
      endcase
    end
    if (cmd_i.emit) begin
      out_cur_q   <= 32'(cur_q);
      out_ps_q    <= projs_q;
      out_pl_q    <= projl_q;
      out_slope_q <= slope_q;
      out_days_q  <= days_q;
      out_grade_q <= grade_d;
    end
  end

  assign status_o.count_ok = (SumW'(cnt_q) >= SumW'(min_q));
  assign status_o.op_done  = arith_done;

  assign done_o            = done_q;
  assign current_usage_o   = out_cur_q;
  assign projected_short_o = out_ps_q;
  assign projected_long_o  = out_pl_q;
  assign growth_slope_o    = out_slope_q;
  assign days_left_o       = out_days_q;
  assign grade_o           = out_grade_q;

endmodule

// File: hw/rtl/ltcf_ctrl.sv
// Controller: takes samples and sequences the fit operations after the last one.
module ltcf_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  input  logic                 end_of_series_i,
  input  ltcf_pkg::dp_status_t status_i,
  output ltcf_pkg::dp_cmd_t    cmd_o,
  output logic                 busy
);
  import ltcf_pkg::*;

  ctrl_state_e state_q, state_d;
  dp_op_e      op_q, op_d;

  // State and operation registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= OP_N_SXY;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    case (state_q)
      ST_IDLE: begin
        if (start && end_of_series_i) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        op_d    = OP_N_SXY;
        state_d = status_i.count_ok ? ST_ISSUE : ST_IDLE;
      end
      ST_ISSUE: begin
        state_d = ST_WAIT;
      end
      ST_WAIT: begin
        if (status_i.op_done) begin
          if (op_q == OP_DAYS) begin
            state_d = ST_EMIT;
          end else begin
            op_d    = next_op(op_q);
            state_d = ST_ISSUE;
          end
        end
      end
      ST_EMIT: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o        = '0;
    cmd_o.op     = op_q;
    busy         = 1'b1;
    case (state_q)
      ST_IDLE: begin
        busy         = 1'b0;
        cmd_o.accept = start;
      end
      ST_CHECK: begin
        cmd_o.clear = !status_i.count_ok;
      end
      ST_ISSUE: begin
        cmd_o.start = 1'b1;
      end
      ST_WAIT: begin
        cmd_o.start = 1'b0;
      end
      ST_EMIT: begin
        cmd_o.emit  = 1'b1;
        cmd_o.clear = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

// File: hw/rtl/linear_trend_capacity_forecast_top.sv
// Top level of the linear trend capacity forecast block.
//
//   Channel   Handshake                Payload
//   sample    start / busy             usage_sample_i, end_of_series_i
//   result    done_o (one-cycle)       current_usage_o .. grade_o
//   config    cfg_we_i, cfg_idx_i      cfg_wdata_i
//
// A sample that is not the last of its series does not make the block busy.
// After the last sample busy stays high through a check state, seven
// 64-step multiplies and three 128-step divides in the shared bit-serial unit,
// each issued in an issue state and awaited in a wait state, and an emit state.
// A series shorter than min_samples goes from the check state back to idle, is cleared and gives no result.
// The result strobe is registered from the emit state and rises as busy drops; it cannot stall.
// Reset returns the sums to zero and the configuration registers to their defaults.
module linear_trend_capacity_forecast_top #(
  parameter int MAX_SAMPLES = 65536,
  parameter int SAMPLE_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [31:0]                   usage_sample_i,
  input  logic                          end_of_series_i,
  input  logic                          cfg_we_i,
  input  logic [ltcf_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ltcf_pkg::CfgDataW-1:0] cfg_wdata_i,
  output logic                          done_o,
  output logic [31:0]                   current_usage_o,
  output logic signed [47:0]            projected_short_o,
  output logic signed [47:0]            projected_long_o,
  output logic signed [47:0]            growth_slope_o,
  output logic signed [16:0]            days_left_o,
  output logic [1:0]                    grade_o
);
  import ltcf_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  ltcf_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .end_of_series_i (end_of_series_i),
    .status_i        (status),
    .cmd_o           (cmd),
    .busy            (busy)
  );

  ltcf_dp #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .usage_sample_i    (usage_sample_i),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .done_o            (done_o),
    .current_usage_o   (current_usage_o),
    .projected_short_o (projected_short_o),
    .projected_long_o  (projected_long_o),
    .growth_slope_o    (growth_slope_o),
    .days_left_o       (days_left_o),
    .grade_o           (grade_o)
  );

endmodule

// File: hw/rtl/ltcf_checker.sv
// Port-level checker for the capacity forecast block and its bind statement.
`include "assert_macros.svh"

module ltcf_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic end_of_series_i,
  input logic done_o
);

  // A result strobe only follows a busy cycle of the fit.
  `ASSERT_CLK(a_done_after_busy, clk_i, rst_ni, done_o |-> $past(busy))
  // One result transaction per series: the strobe always drops again after it rises.
  `ASSERT_CLK(a_done_single, clk_i, rst_ni, done_o |=> !done_o)
  // A sample that is not the last leaves the block ready in the next cycle.
  `ASSERT_CLK(a_mid_sample_fast, clk_i, rst_ni, (start && !busy && !end_of_series_i) |=> !busy)
  // The last sample of a series always makes the block busy.
  `ASSERT_CLK(a_last_sample_busy, clk_i, rst_ni, (start && !busy && end_of_series_i) |=> busy)
  // After a reset edge there is neither a result nor a busy block.
  `ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |=> (!done_o && !busy))

endmodule

bind linear_trend_capacity_forecast_top ltcf_checker u_ltcf_checker (.*);
